@@ rtl/plvs_pkg.sv @@
package plvs_pkg;

    localparam int PosBits    = 14;
    localparam int HeightBits = 12;
    localparam int ChanBits   = 8;
    localparam int CfgBits    = 16;
    localparam int CfgIdxBits = 3;

    // stage map of the shading pipeline
    localparam int StageSum     = 1;
    localparam int StageDenMul  = 2;
    localparam int StageDenAdd  = 3;
    localparam int StageAtFirst = 4;
    localparam int StageAtLast  = 19;
    localparam int StageSqFirst = 2;
    localparam int StageSqLast  = 20;
    localparam int StageNdFirst = 21;
    localparam int StageNdLast  = 54;
    localparam int StageScale   = 55;
    localparam int StageLevel   = 56;
    localparam int StageClip    = 57;
    localparam int NumStages    = 58;

    localparam logic [15:0] C3Floor  = 16'd105;
    localparam logic [46:0] DenOne   = 47'd16777216;    // 2^24
    localparam logic [40:0] AtNumer  = 41'h100_0000_0000; // 2^40
    localparam logic [16:0] AttenMax = 17'h10000;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_LIGHT_X      = 3'd0,
        REG_LIGHT_Y      = 3'd1,
        REG_LIGHT_HEIGHT = 3'd2,
        REG_RED_LEVEL    = 3'd3,
        REG_GREEN_LEVEL  = 3'd4,
        REG_BLUE_LEVEL   = 3'd5,
        REG_CONST_ATTEN  = 3'd6,
        REG_QUAD_ATTEN   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic               active;
        logic [7:0]         old_r;
        logic [7:0]         old_g;
        logic [7:0]         old_b;
        logic [28:0]        sx;
        logic [28:0]        sy;
        logic [28:0]        sz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [29:0]        d2;
        logic [45:0]        cprod;
        logic [46:0]        den;
        logic               at_one;
        logic [40:0]        at_rem;
        logic [15:0]        at_q;
        logic [37:0]        sq_v;
        logic [21:0]        sq_rem;
        logic [18:0]        sq_q;
        logic [36:0]        nd_rem;
        logic [33:0]        nd_q;
        logic [50:0]        scale;
        logic [26:0]        a_r;
        logic [26:0]        a_g;
        logic [26:0]        a_b;
        logic [7:0]         add_r;
        logic [7:0]         add_g;
        logic [7:0]         add_b;
        logic [7:0]         new_r;
        logic [7:0]         new_g;
        logic [7:0]         new_b;
    } t_item;

endpackage

@@ rtl/point_light_vertex_shade_unit.sv @@
// channel   | dir | fields (lowest bit first)
// s_axis    | in  | vertex_x 14, vertex_y 14, vertex_height 12, normal_x/y/z 16 s,
//           |     | old_red/green/blue 8 (112 bits)
// m_axis    | out | add_red/green/blue 8, new_red/green/blue 8 (48 bits)
// cfg       | in  | write enable, 3-bit register index, 16-bit data
//
// one word per cycle sustained while m_axis_tready is high; the result leaves the last of
// 58 register stages set by the bit-per-stage square root (19) and distance divide (34)
// synchronous active-low reset clears stage valids and sets the light registers to their defaults
// each stage holds its word while the next cannot take it, so empty stages fill up
// under an output stall and the input keeps taking words until the pipe is full
module point_light_vertex_shade_unit
    import plvs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // vertex_x, vertex_y, vertex_height, normal_x, normal_y, normal_z,
    // old_red, old_green, old_blue
    input  logic [111:0]           s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // add_red, add_green, add_blue, new_red, new_green, new_blue
    output logic [47:0]            m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_idx,
    input  logic [CfgBits-1:0]     i_cfg_wdata
);

    logic [PosBits-1:0]    r_light_x;
    logic [PosBits-1:0]    r_light_y;
    logic [HeightBits-1:0] r_light_h;
    logic [ChanBits-1:0]   r_red_lvl;
    logic [ChanBits-1:0]   r_grn_lvl;
    logic [ChanBits-1:0]   r_blu_lvl;
    logic [15:0]           r_c1;
    logic [15:0]           r_c3;
    logic [15:0]           w_c3f;

    t_item                 r_pipe [NumStages];
    logic [NumStages-1:0]  r_vld;
    logic [NumStages:0]    w_rdy;
    t_item                 w_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_h <= 12'd32;
            r_red_lvl <= 8'd255;
            r_grn_lvl <= 8'd255;
            r_blu_lvl <= 8'd255;
            r_c1      <= 16'd6554;
            r_c3      <= 16'd32768;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_LIGHT_X:      r_light_x <= i_cfg_wdata[PosBits-1:0];
                REG_LIGHT_Y:      r_light_y <= i_cfg_wdata[PosBits-1:0];
                REG_LIGHT_HEIGHT: r_light_h <= i_cfg_wdata[HeightBits-1:0];
                REG_RED_LEVEL:    r_red_lvl <= i_cfg_wdata[ChanBits-1:0];
                REG_GREEN_LEVEL:  r_grn_lvl <= i_cfg_wdata[ChanBits-1:0];
                REG_BLUE_LEVEL:   r_blu_lvl <= i_cfg_wdata[ChanBits-1:0];
                REG_CONST_ATTEN:  r_c1      <= i_cfg_wdata;
                REG_QUAD_ATTEN:   r_c3      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_c3f = (r_c3 < C3Floor) ? C3Floor : r_c3;

    // first stage: differences and their products
    always_comb begin
        logic signed [14:0] dx;
        logic signed [14:0] dy;
        logic signed [12:0] dz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        dx = $signed({1'b0, r_light_x}) - $signed({1'b0, s_axis_tdata[13:0]});
        dy = $signed({1'b0, r_light_y}) - $signed({1'b0, s_axis_tdata[27:14]});
        dz = $signed({1'b0, r_light_h}) - $signed({1'b0, s_axis_tdata[39:28]});
        nx = $signed(s_axis_tdata[55:40]);
        ny = $signed(s_axis_tdata[71:56]);
        nz = $signed(s_axis_tdata[87:72]);
        w_in       = '0;
        w_in.old_r = s_axis_tdata[95:88];
        w_in.old_g = s_axis_tdata[103:96];
        w_in.old_b = s_axis_tdata[111:104];
        w_in.sx    = 29'(unsigned'(32'(dx * dx)));
        w_in.sy    = 29'(unsigned'(32'(dy * dy)));
        w_in.sz    = 29'(unsigned'(32'(dz * dz)));
        w_in.px    = 32'(nx * dx);
        w_in.py    = 32'(ny * dy);
        w_in.pz    = 32'(nz * dz);
    end

    function automatic t_item f_step(input int k, input t_item c);
        t_item              n;
        logic signed [31:0] dot;
        logic [29:0]        d2;
        logic [21:0]        rem_s;
        logic [20:0]        trial;
        logic [62:0]        dsh;
        logic [52:0]        rsh;
        logic [16:0]        att;
        logic [58:0]        pr;
        logic [58:0]        pg;
        logic [58:0]        pb;
        logic [7:0]         lim;
        int                 i;
        n = c;
        if (k == StageSum) begin
            d2  = 30'(c.sx) + 30'(c.sy) + 30'(c.sz);
            dot = c.px + c.py + c.pz;
            n.d2     = d2;
            n.active = (d2 != '0) && (dot > 0);
            n.nd_rem = n.active ? {dot[30:0], 6'b0} : '0;
            n.nd_q   = '0;
            n.sq_v   = {d2, 8'b0};
            n.sq_rem = '0;
            n.sq_q   = '0;
        end
        if (k == StageDenMul) begin
            n.cprod = c.d2 * w_c3f;
        end
        if (k == StageDenAdd) begin
            n.den    = 47'({r_c1, 8'b0}) + 47'(c.cprod);
            n.at_one = (n.den <= DenOne);
            n.at_rem = AtNumer;
            n.at_q   = '0;
        end
        // restoring square root, two radicand bits a stage
        if (k >= StageSqFirst && k <= StageSqLast) begin
            rem_s = {c.sq_rem[19:0], c.sq_v[37:36]};
            trial = {c.sq_q, 2'b01};
            n.sq_v = {c.sq_v[35:0], 2'b00};
            if (rem_s >= {1'b0, trial}) begin
                n.sq_rem = rem_s - {1'b0, trial};
                n.sq_q   = {c.sq_q[17:0], 1'b1};
            end else begin
                n.sq_rem = rem_s;
                n.sq_q   = {c.sq_q[17:0], 1'b0};
            end
        end
        // attenuation quotient, one bit a stage
        if (k >= StageAtFirst && k <= StageAtLast) begin
            i   = StageAtLast - k;
            dsh = 63'(c.den) << i;
            if ({22'b0, c.at_rem} >= dsh) begin
                n.at_rem  = c.at_rem - dsh[40:0];
                n.at_q[i] = 1'b1;
            end
        end
        // n.l quotient over the distance, one bit a stage
        if (k >= StageNdFirst && k <= StageNdLast) begin
            i   = StageNdLast - k;
            rsh = 53'(c.sq_q) << i;
            if ({16'b0, c.nd_rem} >= rsh) begin
                n.nd_rem  = c.nd_rem - rsh[36:0];
                n.nd_q[i] = 1'b1;
            end
        end
        if (k == StageScale) begin
            att     = c.at_one ? AttenMax : {1'b0, c.at_q};
            n.scale = c.active ? 51'(c.nd_q * att) : '0;
        end
        if (k == StageLevel) begin
            pr    = c.scale * r_red_lvl;
            pg    = c.scale * r_grn_lvl;
            pb    = c.scale * r_blu_lvl;
            n.a_r = pr[58:32];
            n.a_g = pg[58:32];
            n.a_b = pb[58:32];
        end
        if (k == StageClip) begin
            lim     = 8'd255 - c.old_r;
            n.add_r = (c.a_r > 27'(lim)) ? lim : c.a_r[7:0];
            lim     = 8'd255 - c.old_g;
            n.add_g = (c.a_g > 27'(lim)) ? lim : c.a_g[7:0];
            lim     = 8'd255 - c.old_b;
            n.add_b = (c.a_b > 27'(lim)) ? lim : c.a_b[7:0];
            n.new_r = c.old_r + n.add_r;
            n.new_g = c.old_g + n.add_g;
            n.new_b = c.old_b + n.add_b;
        end
        return n;
    endfunction

    assign w_rdy[NumStages] = m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_pipe[0] <= w_in;
        end
    end

    for (genvar k = 0; k < NumStages; k++) begin : g_stage
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        if (k > 0) begin : g_work
            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_pipe[k] <= f_step(k, r_pipe[k-1]);
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end else begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= s_axis_tvalid;
                end
            end
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NumStages-1];
    assign m_axis_tdata  = {r_pipe[NumStages-1].new_b, r_pipe[NumStages-1].new_g,
                            r_pipe[NumStages-1].new_r, r_pipe[NumStages-1].add_b,
                            r_pipe[NumStages-1].add_g, r_pipe[NumStages-1].add_r};

    // new color never falls below the amount added
    a_new_ge_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pipe[StageClip].new_r >= r_pipe[StageClip].add_r) &&
                          (r_pipe[StageClip].new_g >= r_pipe[StageClip].add_g) &&
                          (r_pipe[StageClip].new_b >= r_pipe[StageClip].add_b))
        else $error("new color below added amount");

    // zero distance or back-facing light adds nothing
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_pipe[StageClip].active) |->
            (r_pipe[StageClip].add_r == '0) && (r_pipe[StageClip].add_g == '0) &&
            (r_pipe[StageClip].add_b == '0))
        else $error("addition from an inactive vertex");

    // a lit vertex has a nonzero distance root before the divide
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[StageSqLast] && r_pipe[StageSqLast].active) |->
            (r_pipe[StageSqLast].sq_q != '0))
        else $error("zero distance root on a lit vertex");

endmodule
